// ===== rtl/core/script_lexer_tokenizer_core_defines.svh =====
// Assertion macros for the lexer core.
`ifndef SCRIPT_LEXER_TOKENIZER_CORE_DEFINES_SVH
`define SCRIPT_LEXER_TOKENIZER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SLT_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication.
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// ===== rtl/core/slt_pkg.sv =====
// Shared types and constants of the lexer core.
package slt_pkg;
    localparam logic [3:0] MODE_IDLE   = 4'd0;
    localparam logic [3:0] MODE_IDENT  = 4'd1;
    localparam logic [3:0] MODE_NUM    = 4'd2;
    localparam logic [3:0] MODE_NUMDOT = 4'd3;
    localparam logic [3:0] MODE_FRAC   = 4'd4;
    localparam logic [3:0] MODE_STR    = 4'd5;
    localparam logic [3:0] MODE_OP     = 4'd6;
    localparam logic [3:0] MODE_LCOM   = 4'd7;
    localparam logic [3:0] MODE_BCOM   = 4'd8;

    localparam logic [5:0] KIND_END   = 6'd0;
    localparam logic [5:0] KIND_ERR   = 6'd1;
    localparam logic [5:0] KIND_IDENT = 6'd2;
    localparam logic [5:0] KIND_NUM   = 6'd3;
    localparam logic [5:0] KIND_STR   = 6'd4;
    localparam logic [5:0] KIND_DOT   = 6'd25;
    localparam logic [5:0] KIND_SLASH = 6'd30;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_UNSTR = 2'd2;

    // Token before its line is known: line attached by the back end.
    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [63:0] off;
        logic [63:0] len;
    } t_tok;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [5:0] lone_op(input logic [7:0] c);
        case (c)
            8'h2d: return 6'd27;
            8'h2b: return 6'd29;
            8'h2f: return 6'd30;
            8'h2a: return 6'd32;
            8'h21: return 6'd34;
            8'h3d: return 6'd36;
            8'h3c: return 6'd39;
            8'h3e: return 6'd42;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] pair_op(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        k = 6'd0;
        if (b == 8'h3d) begin
            case (a)
                8'h2d: k = 6'd26;
                8'h2b: k = 6'd28;
                8'h21: k = 6'd33;
                8'h3d: k = 6'd35;
                8'h3c: k = 6'd37;
                8'h3e: k = 6'd40;
                default: k = 6'd0;
            endcase
        end else if (a == 8'h2a && b == 8'h2a) begin
            k = 6'd31;
        end else if (a == 8'h3c && b == 8'h3c) begin
            k = 6'd38;
        end else if (a == 8'h3e && b == 8'h3e) begin
            k = 6'd41;
        end
        return k;
    endfunction

    function automatic logic [5:0] simple_op(input logic [7:0] c);
        case (c)
            8'h28: return 6'd19;
            8'h29: return 6'd20;
            8'h7b: return 6'd21;
            8'h7d: return 6'd22;
            8'h3b: return 6'd23;
            8'h2c: return 6'd24;
            8'h2e: return 6'd25;
            8'h5e: return 6'd43;
            8'h7c: return 6'd44;
            8'h26: return 6'd45;
            8'h25: return 6'd46;
            8'h5b: return 6'd47;
            8'h5d: return 6'd48;
            default: return 6'd0;
        endcase
    endfunction

    // Keyword match on the first bytes of an identifier (first byte in [7:0]).
    function automatic logic [5:0] ident_kind(input logic [47:0] p, input logic [2:0] n);
        logic [5:0] k;
        k = KIND_IDENT;
        case (n)
            3'd2: begin
                if (p[15:0] == 16'h6669) k = 6'd10;      // if
                if (p[15:0] == 16'h726f) k = 6'd13;      // or
            end
            3'd3: begin
                if (p[23:0] == 24'h646e61) k = 6'd5;     // and
                if (p[23:0] == 24'h666564) k = 6'd6;     // def
                if (p[23:0] == 24'h726f66) k = 6'd9;     // for
                if (p[23:0] == 24'h74656c) k = 6'd11;    // let
            end
            3'd4: begin
                if (p[31:0] == 32'h65736c65) k = 6'd7;   // else
                if (p[31:0] == 32'h6c6c756e) k = 6'd12;  // null
                if (p[31:0] == 32'h65757274) k = 6'd15;  // true
                if (p[31:0] == 32'h65707974) k = 6'd16;  // type
                if (p[31:0] == 32'h74696177) k = 6'd17;  // wait
            end
            3'd5: begin
                if (p[39:0] == 40'h65736c6166) k = 6'd8;   // false
                if (p[39:0] == 40'h656c696877) k = 6'd18;  // while
            end
            3'd6: begin
                if (p[47:0] == 48'h6e7275746572) k = 6'd14; // return
            end
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction
endpackage

// ===== rtl/core/slt_stream_if.sv =====
// Valid/ready channel interface carrying a generic payload.
interface slt_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/slt_front.sv =====
// Front end: scan state machine, turns one byte into up to three tokens.
module slt_front #(
    parameter int PW = 32,
    parameter int LW = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [7:0]          i_byte,
    input  logic                i_eoi,
    output logic [1:0]          o_cnt,
    output slt_pkg::t_tok [2:0] o_tok,
    output logic [LW-1:0]       o_line_pre
);
    logic [3:0]    r_mode, n_mode;
    logic [PW-1:0] r_start, n_start;
    logic [PW-1:0] r_pos;
    logic [LW-1:0] r_line, n_line;
    logic [47:0]   r_pfx, n_pfx;
    logic [2:0]    r_icnt, n_icnt;
    logic [7:0]    r_pend, n_pend;
    logic          r_sq, n_sq, r_star, n_star;

    logic [PW-1:0] pos1, dotpos;
    logic          done;
    logic [5:0]    k;

    localparam logic [LW-1:0] LINE_MAX = {LW{1'b1}};

    assign pos1   = r_pos + PW'(1);
    assign dotpos = r_pos - PW'(1);

    function automatic logic [63:0] span(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW-1:0] d;
        d = b - a;
        return 64'(d);
    endfunction

    function automatic slt_pkg::t_tok mk(input logic [5:0] kd, input logic [1:0] e,
                                         input logic [PW-1:0] off, input logic [63:0] len);
        slt_pkg::t_tok t;
        t.kind = kd;
        t.err  = e;
        t.off  = 64'(off);
        t.len  = len;
        return t;
    endfunction

    always_comb begin
        n_mode = r_mode; n_start = r_start; n_line = r_line; n_pfx = r_pfx;
        n_icnt = r_icnt; n_pend = r_pend; n_sq = r_sq; n_star = r_star;
        o_cnt = 2'd0;
        o_tok = '0;
        o_line_pre = r_line;
        done = 1'b0;
        k = 6'd0;
        if (i_eoi) begin
            case (r_mode)
                slt_pkg::MODE_IDENT: begin
                    o_tok[0] = mk(slt_pkg::ident_kind(r_pfx, r_icnt), slt_pkg::ERR_NONE,
                                  r_start, span(r_start, r_pos));
                    o_cnt = 2'd1;
                end
                slt_pkg::MODE_NUM, slt_pkg::MODE_FRAC: begin
                    o_tok[0] = mk(slt_pkg::KIND_NUM, slt_pkg::ERR_NONE, r_start,
                                  span(r_start, r_pos));
                    o_cnt = 2'd1;
                end
                slt_pkg::MODE_NUMDOT: begin
                    o_tok[0] = mk(slt_pkg::KIND_NUM, slt_pkg::ERR_NONE, r_start,
                                  span(r_start, dotpos));
                    o_tok[1] = mk(slt_pkg::KIND_DOT, slt_pkg::ERR_NONE, dotpos, 64'd1);
                    o_cnt = 2'd2;
                end
                slt_pkg::MODE_STR: begin
                    o_tok[0] = mk(slt_pkg::KIND_ERR, slt_pkg::ERR_UNSTR, r_start,
                                  span(r_start, r_pos));
                    o_cnt = 2'd1;
                end
                slt_pkg::MODE_OP: begin
                    o_tok[0] = mk(slt_pkg::lone_op(r_pend), slt_pkg::ERR_NONE, r_start, 64'd1);
                    o_cnt = 2'd1;
                end
                default: o_cnt = 2'd0;
            endcase
            o_tok[o_cnt] = mk(slt_pkg::KIND_END, slt_pkg::ERR_NONE, r_pos, 64'd0);
            o_cnt = o_cnt + 2'd1;
            n_mode = slt_pkg::MODE_IDLE;
            n_star = 1'b0;
        end else begin
            case (r_mode)
                slt_pkg::MODE_IDENT: begin
                    if (slt_pkg::is_letter(i_byte) || slt_pkg::is_num(i_byte)) begin
                        if (r_icnt < 3'd6) n_pfx[r_icnt*8 +: 8] = i_byte;
                        if (r_icnt < 3'd7) n_icnt = r_icnt + 3'd1;
                        done = 1'b1;
                    end else begin
                        o_tok[0] = mk(slt_pkg::ident_kind(r_pfx, r_icnt), slt_pkg::ERR_NONE,
                                      r_start, span(r_start, r_pos));
                        o_cnt = 2'd1;
                        n_mode = slt_pkg::MODE_IDLE;
                    end
                end
                slt_pkg::MODE_NUM: begin
                    if (slt_pkg::is_num(i_byte)) begin
                        done = 1'b1;
                    end else if (i_byte == 8'h2e) begin
                        n_mode = slt_pkg::MODE_NUMDOT; done = 1'b1;
                    end else begin
                        o_tok[0] = mk(slt_pkg::KIND_NUM, slt_pkg::ERR_NONE, r_start,
                                      span(r_start, r_pos));
                        o_cnt = 2'd1;
                        n_mode = slt_pkg::MODE_IDLE;
                    end
                end
                slt_pkg::MODE_NUMDOT: begin
                    if (slt_pkg::is_num(i_byte)) begin
                        n_mode = slt_pkg::MODE_FRAC; done = 1'b1;
                    end else begin
                        o_tok[0] = mk(slt_pkg::KIND_NUM, slt_pkg::ERR_NONE, r_start,
                                      span(r_start, dotpos));
                        o_tok[1] = mk(slt_pkg::KIND_DOT, slt_pkg::ERR_NONE, dotpos, 64'd1);
                        o_cnt = 2'd2;
                        n_mode = slt_pkg::MODE_IDLE;
                    end
                end
                slt_pkg::MODE_FRAC: begin
                    if (slt_pkg::is_num(i_byte)) begin
                        done = 1'b1;
                    end else begin
                        o_tok[0] = mk(slt_pkg::KIND_NUM, slt_pkg::ERR_NONE, r_start,
                                      span(r_start, r_pos));
                        o_cnt = 2'd1;
                        n_mode = slt_pkg::MODE_IDLE;
                    end
                end
                slt_pkg::MODE_STR: begin
                    done = 1'b1;
                    if (i_byte == (r_sq ? 8'h27 : 8'h22)) begin
                        o_tok[0] = mk(slt_pkg::KIND_STR, slt_pkg::ERR_NONE, r_start,
                                      span(r_start, pos1));
                        o_cnt = 2'd1;
                        n_mode = slt_pkg::MODE_IDLE;
                    end else if (i_byte == 8'h0a) begin
                        if (r_line != LINE_MAX) n_line = r_line + LW'(1);
                    end
                end
                slt_pkg::MODE_OP: begin
                    if (r_pend == 8'h2f) begin
                        if (i_byte == 8'h2f) begin
                            n_mode = slt_pkg::MODE_LCOM; done = 1'b1;
                        end else if (i_byte == 8'h2a) begin
                            n_mode = slt_pkg::MODE_BCOM; n_star = 1'b0; done = 1'b1;
                        end else begin
                            o_tok[0] = mk(slt_pkg::KIND_SLASH, slt_pkg::ERR_NONE, r_start,
                                          64'd1);
                            o_cnt = 2'd1;
                            n_mode = slt_pkg::MODE_IDLE;
                        end
                    end else begin
                        k = slt_pkg::pair_op(r_pend, i_byte);
                        if (k != 6'd0) begin
                            o_tok[0] = mk(k, slt_pkg::ERR_NONE, r_start, 64'd2);
                            done = 1'b1;
                        end else begin
                            o_tok[0] = mk(slt_pkg::lone_op(r_pend), slt_pkg::ERR_NONE,
                                          r_start, 64'd1);
                        end
                        o_cnt = 2'd1;
                        n_mode = slt_pkg::MODE_IDLE;
                    end
                end
                slt_pkg::MODE_LCOM: begin
                    if (i_byte == 8'h0a) n_mode = slt_pkg::MODE_IDLE;
                    else done = 1'b1;
                end
                slt_pkg::MODE_BCOM: begin
                    done = 1'b1;
                    if (r_star && i_byte == 8'h2f) begin
                        n_mode = slt_pkg::MODE_IDLE; n_star = 1'b0;
                    end else begin
                        n_star = (i_byte == 8'h2a);
                    end
                end
                default: n_mode = slt_pkg::MODE_IDLE;
            endcase
            if (!done) begin
                if (i_byte == 8'h20 || i_byte == 8'h09 || i_byte == 8'h0d) begin
                    n_start = n_start;
                end else if (i_byte == 8'h0a) begin
                    if (r_line != LINE_MAX) n_line = r_line + LW'(1);
                end else begin
                    n_start = r_pos;
                    if (slt_pkg::is_letter(i_byte)) begin
                        n_mode = slt_pkg::MODE_IDENT;
                        n_pfx[7:0] = i_byte;
                        n_icnt = 3'd1;
                    end else if (slt_pkg::is_num(i_byte)) begin
                        n_mode = slt_pkg::MODE_NUM;
                    end else if (i_byte == 8'h22 || i_byte == 8'h27) begin
                        n_mode = slt_pkg::MODE_STR;
                        n_sq = (i_byte == 8'h27);
                    end else if (slt_pkg::lone_op(i_byte) != 6'd0) begin
                        n_mode = slt_pkg::MODE_OP;
                        n_pend = i_byte;
                    end else begin
                        if (slt_pkg::simple_op(i_byte) != 6'd0)
                            o_tok[o_cnt] = mk(slt_pkg::simple_op(i_byte), slt_pkg::ERR_NONE,
                                              r_pos, 64'd1);
                        else
                            o_tok[o_cnt] = mk(slt_pkg::KIND_ERR, slt_pkg::ERR_CHAR, r_pos,
                                              64'd1);
                        o_cnt = o_cnt + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= slt_pkg::MODE_IDLE;
            r_start <= '0; r_pos <= '0; r_line <= LW'(1);
            r_pfx <= '0; r_icnt <= '0; r_pend <= '0; r_sq <= 1'b0; r_star <= 1'b0;
        end else if (i_go) begin
            r_mode <= n_mode; r_start <= n_start; r_line <= n_line; r_pfx <= n_pfx;
            r_icnt <= n_icnt; r_pend <= n_pend; r_sq <= n_sq; r_star <= n_star;
            if (!i_eoi) r_pos <= pos1;
        end
    end
endmodule

// ===== rtl/core/slt_queue.sv =====
// Token queue between the back end and the output port.
module slt_queue #(
    parameter int W = 8,
    parameter int DEPTH = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    slt_stream_if.sink   s_in,
    slt_stream_if.source m_out,
    output logic [$clog2(DEPTH+1)-1:0] o_free
);
    localparam int AW = $clog2(DEPTH);
    logic [W-1:0]   r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           push, pop;

    assign push = s_in.valid && s_in.ready;
    assign pop  = m_out.valid && m_out.ready;
    assign s_in.ready  = r_cnt != (AW+1)'(DEPTH);
    assign m_out.valid = r_cnt != '0;
    assign m_out.data  = r_mem[r_rp];
    assign o_free = ($clog2(DEPTH+1))'((AW+1)'(DEPTH) - r_cnt);

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= s_in.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== rtl/core/slt_back.sv =====
// Back end: serialises a staged batch of up to three tokens into the queue.
module slt_back #(
    parameter int W = 8,
    parameter int LW = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [1:0]          i_cnt,
    input  slt_pkg::t_tok [2:0] i_tok,
    input  logic [LW-1:0]       i_line_pre,
    output logic                o_busy,
    slt_stream_if.source        m_out
);
    slt_pkg::t_tok [2:0] r_tok;
    logic [1:0]    r_cnt, r_idx;
    logic [LW-1:0] r_lpre;
    slt_pkg::t_tok cur;
    logic [15:0]   len;
    logic [LW-1:0] ln;
    logic          last;

    assign cur  = r_tok[r_idx];
    assign len  = (cur.len > 64'd65535) ? 16'hffff : cur.len[15:0];
    assign last = (r_idx + 2'd1) == r_cnt;
    // Every token of a batch is raised before the byte can bump the line.
    assign ln   = r_lpre;
    assign o_busy = r_cnt != 2'd0;
    assign m_out.valid = o_busy;
    assign m_out.data = W'({cur.kind, cur.err, 32'(cur.off), len, 24'(ln), last});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_tok; r_lpre <= i_line_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt; r_idx <= '0;
        end else if (o_busy && m_out.ready) begin
            r_idx <= r_idx + 2'd1;
            if (last) r_cnt <= '0;
        end
    end
endmodule

// ===== rtl/core/script_lexer_tokenizer_core.sv =====
// Top level of the streaming lexer core.
// Usage:
//   s_in carries one source byte per request ({text_byte, end_of_input});
//   end_of_input flushes any open token and adds an end token.
//   m_out carries tokens {kind, error, offset, length, line, last_of_run};
//   last_of_run marks the final token caused by one input request.
// Path: a token caused by a byte passes one registered batch stage, then one
//   queue stage, before it can be taken at m_out.
// Throughput: one byte per cycle while each byte raises at most one token
//   and the token queue has four free slots; a byte raising two or three
//   tokens holds s_in while the back end serialises them.
// Reset: synchronous, active low; mode idle, position 0, line 1, queue empty.
// Stall: when m_out.ready is low the queue fills and s_in.ready drops once
//   fewer than four free slots remain; nothing is lost.
// Line numbers are the count before the byte, as every token is raised
//   before that byte's newline is counted.
module script_lexer_tokenizer_core #(
    parameter int POSITION_WIDTH = 32,
    parameter int LINE_WIDTH = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slt_stream_if.sink   s_in,
    slt_stream_if.source m_out
);
    `include "script_lexer_tokenizer_core_defines.svh"

    localparam int TW = 6 + 2 + 32 + 16 + 24 + 1;
    localparam int QD = 8;

    logic                go, busy, room;
    logic [1:0]          f_cnt;
    slt_pkg::t_tok [2:0] f_tok;
    logic [LINE_WIDTH-1:0] l_pre;
    logic [$clog2(QD+1)-1:0] q_free;

    slt_stream_if #(.W(TW)) q_if ();

    // A new batch may load only when the back end is empty or just finishing,
    // and the queue keeps room for a full batch.
    assign room = (!busy || (q_if.ready && q_if.valid && q_if.data[0])) &&
                  q_free >= ($clog2(QD+1))'(4);
    assign s_in.ready = room;
    assign go = s_in.valid && s_in.ready;

    slt_front #(.PW(POSITION_WIDTH), .LW(LINE_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go),
        .i_byte(s_in.data[8:1]), .i_eoi(s_in.data[0]),
        .o_cnt(f_cnt), .o_tok(f_tok), .o_line_pre(l_pre)
    );

    slt_back #(.W(TW), .LW(LINE_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(go && f_cnt != 2'd0),
        .i_cnt(f_cnt), .i_tok(f_tok), .i_line_pre(l_pre),
        .o_busy(busy), .m_out(q_if)
    );

    slt_queue #(.W(TW), .DEPTH(QD)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(q_if), .m_out(m_out), .o_free(q_free)
    );

    `SLT_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, q_if.valid, q_if.ready,
                     "token queue overflow")
    `SLT_ASSERT_NEXT(a_eoi_emits, i_clk, i_rst_n, go && s_in.data[0], busy,
                     "end of input produced no token")
endmodule
